>>> hw/rtl/hbk_pkg.sv
// Shared types and constants for the boot keyboard report differ.
// Used by the front end, the job queue, the event sequencer and the top level.
package hbk_pkg;

  localparam int MOD_BITS  = 8;
  localparam int KEY_SLOTS = 6;
  localparam int N_EVENTS  = MOD_BITS + 2 * KEY_SLOTS;
  localparam int EV_W      = $clog2(N_EVENTS);
  localparam int SLOT_W    = $clog2(KEY_SLOTS);
  localparam int MOD_W     = $clog2(MOD_BITS);

  localparam logic [7:0] MOD_KEY_BASE = 8'hE0;

  typedef logic [KEY_SLOTS-1:0][7:0] keys_t;

  // Event mask layout: modifier bits first, then for each slot a release bit
  // followed by a press bit.
  typedef struct packed {
    logic [MOD_BITS-1:0] mods;
    keys_t               prev_keys;
    keys_t               new_keys;
    logic [N_EVENTS-1:0] ev_mask;
  } job_t;

endpackage

>>> hw/rtl/hbk_front.sv
// Front end: keeps the previous good report and classifies each request
// into a mask of pending events. Depends on hbk_pkg.
module hbk_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     status_ok,
  input  logic [7:0]               mods,
  input  hbk_pkg::keys_t           keys,
  output hbk_pkg::job_t            job,
  output logic                     job_valid
);
  import hbk_pkg::*;

  logic [MOD_BITS-1:0]  prev_mods_r;
  logic [MOD_BITS-1:0]  prev_mods_nxt;
  keys_t                prev_keys_r;
  keys_t                prev_keys_nxt;
  logic [KEY_SLOTS-1:0] old_gone;
  logic [KEY_SLOTS-1:0] new_fresh;
  logic [N_EVENTS-1:0]  mask;
  logic                 take;

  assign take = accept & status_ok;

  always_comb begin
    for (int s = 0; s < KEY_SLOTS; s++) begin
      old_gone[s]  = 1'b1;
      new_fresh[s] = 1'b1;
      for (int t = 0; t < KEY_SLOTS; t++) begin
        if (keys[t] == prev_keys_r[s]) begin
          old_gone[s] = 1'b0;
        end
        if (prev_keys_r[t] == keys[s]) begin
          new_fresh[s] = 1'b0;
        end
      end
    end
    mask[MOD_BITS-1:0] = prev_mods_r ^ mods;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      mask[MOD_BITS + 2*s]     = old_gone[s];
      mask[MOD_BITS + 2*s + 1] = new_fresh[s];
    end
  end

  always_comb begin
    job.mods      = mods;
    job.prev_keys = prev_keys_r;
    job.new_keys  = keys;
    job.ev_mask   = mask;
  end

  // A report that changes nothing still replaces the stored one, but queues no job.
  assign job_valid = take & (|mask);

  assign prev_mods_nxt = take ? mods : prev_mods_r;
  assign prev_keys_nxt = take ? keys : prev_keys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mods_r <= '0;
      prev_keys_r <= '0;
    end else begin
      prev_mods_r <= prev_mods_nxt;
      prev_keys_r <= prev_keys_nxt;
    end
  end

endmodule

>>> hw/rtl/hbk_job_fifo.sv
// Short queue of classified jobs between the front end and the sequencer.
// Depends on hbk_pkg.
module hbk_job_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hbk_pkg::job_t wr_job,
  input  logic          pop,
  output hbk_pkg::job_t rd_job,
  output logic          head_valid,
  output logic          full
);
  import hbk_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;
  assign rd_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |=> full && $stable(wr_ptr_r))
    else $error("job queue written while full");

endmodule

>>> hw/rtl/hbk_seq.sv
// Event sequencer: walks the pending mask of the head job, lowest event first,
// and drives the result register. Depends on hbk_pkg.
module hbk_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  hbk_pkg::job_t job,
  input  logic          head_valid,
  output logic          job_pop,
  input  logic          pop,
  output logic          empty,
  output logic          is_press,
  output logic [7:0]    key_code,
  output logic          last_event
);
  import hbk_pkg::*;

  logic [N_EVENTS-1:0] done_r, done_nxt;
  logic [N_EVENTS-1:0] pending;
  logic [N_EVENTS-1:0] sel_bit;
  logic [N_EVENTS-1:0] rest;
  logic [EV_W-1:0]     sel;
  logic [EV_W-1:0]     k;
  logic [SLOT_W-1:0]   slot;
  logic                out_free;
  logic                emit;
  logic                ev_press;
  logic [7:0]          ev_code;

  logic                out_valid_r, out_valid_nxt;
  logic                out_press_r;
  logic [7:0]          out_code_r;
  logic                out_last_r;

  assign pending = head_valid ? (job.ev_mask & ~done_r) : '0;

  always_comb begin
    sel = '0;
    for (int i = N_EVENTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = EV_W'(i);
      end
    end
  end

  assign sel_bit = N_EVENTS'(1) << sel;
  assign rest    = pending & ~sel_bit;

  // The result register takes a new event from the head job when it is empty or its current one leaves.
  assign out_free = ~out_valid_r | pop;
  assign emit     = head_valid & out_free;
  assign job_pop  = emit & ~(|rest);

  assign k    = sel - EV_W'(MOD_BITS);
  assign slot = k[SLOT_W:1];

  always_comb begin
    if (sel < EV_W'(MOD_BITS)) begin
      ev_press = job.mods[sel[MOD_W-1:0]];
      ev_code  = MOD_KEY_BASE + 8'(sel[MOD_W-1:0]);
    end else if (k[0]) begin
      ev_press = 1'b1;
      ev_code  = job.new_keys[slot];
    end else begin
      ev_press = 1'b0;
      ev_code  = job.prev_keys[slot];
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (job_pop) begin
      done_nxt = '0;
    end else if (emit) begin
      done_nxt = done_r | sel_bit;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_press_r <= ev_press;
      out_code_r  <= ev_code;
      out_last_r  <= job_pop;
    end
  end

  assign empty      = ~out_valid_r;
  assign is_press   = out_press_r;
  assign key_code   = out_code_r;
  assign last_event = out_last_r;

  a_head_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (pending != '0))
    else $error("queued job has no pending event");

  a_last_marks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (out_valid_r && out_last_r && done_r == '0))
    else $error("finished job not marked by its last event");

  a_done_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (done_r == '0))
    else $error("progress mask set with no job at the head");

endmodule

>>> hw/rtl/hid_boot_report_key_event_diff.sv
// Boot keyboard report differ: turns each report into key press/release events.
// An accepted report is written into the job queue, and the sequencer then registers its
// events into the result register. Throughput: one report per cycle while the queue has
// room; events leave one per cycle while the receiver pops, so a report yielding N events
// (up to 20) holds the sequencer until all have left. Failed or unchanged reports yield none.
// Reset empties the queue and result register and clears the stored report to zeros.
module hid_boot_report_key_event_diff #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_status_ok,
  input  logic [7:0] in_modifier_bits,
  input  logic [7:0] in_slot_key_0,
  input  logic [7:0] in_slot_key_1,
  input  logic [7:0] in_slot_key_2,
  input  logic [7:0] in_slot_key_3,
  input  logic [7:0] in_slot_key_4,
  input  logic [7:0] in_slot_key_5,
  output logic       empty,
  input  logic       pop,
  output logic       out_is_press,
  output logic [7:0] out_key_code,
  output logic       out_last_event
);
  import hbk_pkg::*;

  keys_t in_keys;
  job_t  wr_job;
  job_t  rd_job;
  logic  job_valid;
  logic  head_valid;
  logic  job_pop;
  logic  accept;

  assign in_keys[0] = in_slot_key_0;
  assign in_keys[1] = in_slot_key_1;
  assign in_keys[2] = in_slot_key_2;
  assign in_keys[3] = in_slot_key_3;
  assign in_keys[4] = in_slot_key_4;
  assign in_keys[5] = in_slot_key_5;

  assign accept = push & ~full;

  hbk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .status_ok (in_status_ok),
    .mods      (in_modifier_bits),
    .keys      (in_keys),
    .job       (wr_job),
    .job_valid (job_valid)
  );

  hbk_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_valid),
    .wr_job     (wr_job),
    .pop        (job_pop),
    .rd_job     (rd_job),
    .head_valid (head_valid),
    .full       (full)
  );

  hbk_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (rd_job),
    .head_valid (head_valid),
    .job_pop    (job_pop),
    .pop        (pop),
    .empty      (empty),
    .is_press   (out_is_press),
    .key_code   (out_key_code),
    .last_event (out_last_event)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for the boot keyboard report differ: directed, random and back-pressure runs
// with a built-in prediction of the key events. Depends only on hbk_pkg and the top module.
module testbench;
  import hbk_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_OFF_LEN   = 300;

  typedef struct packed {
    logic       is_press;
    logic [7:0] key_code;
    logic       last_event;
  } key_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_status_ok = 1'b0;
  logic [7:0] in_modifier_bits = 8'h00;
  logic [7:0] in_slot_key_0 = 8'h00;
  logic [7:0] in_slot_key_1 = 8'h00;
  logic [7:0] in_slot_key_2 = 8'h00;
  logic [7:0] in_slot_key_3 = 8'h00;
  logic [7:0] in_slot_key_4 = 8'h00;
  logic [7:0] in_slot_key_5 = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_is_press;
  logic [7:0] out_key_code;
  logic       out_last_event;

  // Report last taken by the block, as the prediction sees it.
  logic [7:0] held_mods = 8'h00;
  keys_t      held_keys = '0;

  key_event_t pending_events[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_len = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int reports_sent = 0;
  int failed_reports = 0;
  int events_checked = 0;
  int busiest_report = 0;
  int idle_cycles = 0;

  hid_boot_report_key_event_diff DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_status_ok    (in_status_ok),
    .in_modifier_bits(in_modifier_bits),
    .in_slot_key_0   (in_slot_key_0),
    .in_slot_key_1   (in_slot_key_1),
    .in_slot_key_2   (in_slot_key_2),
    .in_slot_key_3   (in_slot_key_3),
    .in_slot_key_4   (in_slot_key_4),
    .in_slot_key_5   (in_slot_key_5),
    .empty           (empty),
    .pop             (pop),
    .out_is_press    (out_is_press),
    .out_key_code    (out_key_code),
    .out_last_event  (out_last_event)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic keys_t pack_slots(input logic [7:0] k0, k1, k2, k3, k4, k5);
    keys_t slots;
    slots[0] = k0;
    slots[1] = k1;
    slots[2] = k2;
    slots[3] = k3;
    slots[4] = k4;
    slots[5] = k5;
    return slots;
  endfunction

  function automatic bit key_in_set(input keys_t slots, input logic [7:0] code);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (slots[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the events of one good report and makes it the held report.
  function automatic void predict_key_events(input logic [7:0] mods, input keys_t keys);
    key_event_t evs[N_EVENTS];
    logic [7:0] toggled;
    int n;
    n = 0;
    toggled = held_mods ^ mods;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (toggled[i]) begin
        evs[n] = '{is_press: mods[i], key_code: 8'(MOD_KEY_BASE + i), last_event: 1'b0};
        n++;
      end
    end
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (!key_in_set(keys, held_keys[s])) begin
        evs[n] = '{is_press: 1'b0, key_code: held_keys[s], last_event: 1'b0};
        n++;
      end
      if (!key_in_set(held_keys, keys[s])) begin
        evs[n] = '{is_press: 1'b1, key_code: keys[s], last_event: 1'b0};
        n++;
      end
    end
    if (n > 0) evs[n-1].last_event = 1'b1;
    for (int i = 0; i < n; i++) pending_events.push_back(evs[i]);
    if (n > busiest_report) busiest_report = n;
    held_mods = mods;
    held_keys = keys;
  endfunction

  function automatic logic [7:0] pick_key();
    logic [7:0] common_keys[8] = '{8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h2C, 8'hE1};
    if ($urandom_range(1) == 0) return common_keys[$urandom_range(7)];
    return 8'($urandom);
  endfunction

  // Offers one report and returns at the edge where it is accepted.
  task automatic send_report(input logic ok, input logic [7:0] mods, input keys_t keys);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_status_ok     <= ok;
    in_modifier_bits <= mods;
    in_slot_key_0    <= keys[0];
    in_slot_key_1    <= keys[1];
    in_slot_key_2    <= keys[2];
    in_slot_key_3    <= keys[3];
    in_slot_key_4    <= keys[4];
    in_slot_key_5    <= keys[5];
    @(posedge clk);
    while (full) @(posedge clk);
    reports_sent++;
    if (ok) predict_key_events(mods, keys);
    else failed_reports++;
  endtask

  // Mostly small edits of the held report, as a real keyboard would send them,
  // with failed transfers, repeats and fully random reports mixed in.
  task automatic make_random_report(output logic ok, output logic [7:0] mods,
                                    output keys_t keys);
    int pick;
    int edits;
    int a;
    int b;
    logic [7:0] tmp;
    pick = $urandom_range(99);
    ok   = 1'b1;
    mods = held_mods;
    keys = held_keys;
    if (pick < 8) begin
      ok   = 1'b0;
      mods = 8'($urandom);
      keys = keys_t'({$urandom, $urandom});
    end else if (pick < 14) begin
      // Same report again: nothing should come out.
    end else if (pick < 26) begin
      mods = 8'($urandom);
      keys = keys_t'({$urandom, $urandom});
    end else begin
      edits = $urandom_range(2);
      for (int i = 0; i < edits; i++) mods[$urandom_range(MOD_BITS-1)] ^= 1'b1;
      edits = $urandom_range(3);
      for (int i = 0; i < edits; i++) keys[$urandom_range(KEY_SLOTS-1)] = pick_key();
      if ($urandom_range(4) == 0) begin
        a = $urandom_range(KEY_SLOTS-1);
        b = $urandom_range(KEY_SLOTS-1);
        tmp     = keys[a];
        keys[a] = keys[b];
        keys[b] = tmp;
      end
      if ($urandom_range(5) == 0) keys[$urandom_range(KEY_SLOTS-1)] = 8'h00;
    end
  endtask

  task automatic test_directed_reports();
    send_report(1'b1, 8'h00, pack_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1'b0, 8'hFF, pack_slots(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(1'b1, 8'hFF, pack_slots(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06));
    send_report(1'b1, 8'hFF, pack_slots(8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01));
    send_report(1'b0, 8'h00, pack_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1'b1, 8'h00, pack_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1'b1, 8'h01, pack_slots(8'h04, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00));
    send_report(1'b1, 8'h80, pack_slots(8'hFF, 8'h80, 8'h7F, 8'h00, 8'h04, 8'h01));
    send_report(1'b1, 8'h80, pack_slots(8'hFF, 8'h80, 8'h7F, 8'h00, 8'h04, 8'h01));
    send_report(1'b1, 8'h55, pack_slots(8'hAA, 8'h55, 8'hFF, 8'hFE, 8'h01, 8'h00));
    send_report(1'b1, 8'hAA, pack_slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1'b1, 8'h00, pack_slots(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(1'b1, 8'hFF, pack_slots(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(1'b0, 8'h00, pack_slots(8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66));
    send_report(1'b1, 8'h0F, pack_slots(8'hE0, 8'hE1, 8'hE7, 8'h00, 8'h01, 8'hFE));
    send_report(1'b1, 8'hF0, pack_slots(8'hE1, 8'hE0, 8'h01, 8'h01, 8'h01, 8'h00));
  endtask

  task automatic test_random_reports(input int count, input int tx_pct, input int rx_pct);
    logic ok;
    logic [7:0] mods;
    keys_t keys;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      make_random_report(ok, mods, keys);
      send_report(ok, mods, keys);
    end
  endtask

  // The receiver stops taking events for a long stretch while reports keep coming,
  // so the queue fills and the block has to refuse requests.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_len = HOLD_OFF_LEN;
    test_random_reports(40, 0, 0);
  endtask

  initial begin : result_receiver
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        pop <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      pop <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && pop && !empty) begin
      events_checked++;
      if (pending_events.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected event: press=%0b code=%02h last=%0b",
                   out_is_press, out_key_code, out_last_event);
      end else begin
        want = pending_events.pop_front();
        if (out_is_press !== want.is_press || out_key_code !== want.key_code ||
            out_last_event !== want.last_event) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"event mismatch: expected press=%0b code=%02h last=%0b, ",
                      "got press=%0b code=%02h last=%0b"},
                     want.is_press, want.key_code, want.last_event,
                     out_is_press, out_key_code, out_last_event);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 22;
    rx_idle_pct = 88;
    test_directed_reports();
    test_random_reports(120, 22, 88);
    test_random_reports(120, 88, 22);
    test_random_reports(70, 0, 0);
    test_backpressure();

    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      $display("%0d expected events never arrived", pending_events.size());
      fail_count += pending_events.size();
    end

    $display("Sent %0d reports (%0d failed transfers), checked %0d key events,",
             reports_sent, failed_reports, events_checked);
    $display("at most %0d from one report; mismatches seen: %0d.",
             busiest_report, mismatch_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> hid_boot_report_key_event_diff.f
hw/rtl/hbk_pkg.sv
hw/rtl/hbk_front.sv
hw/rtl/hbk_job_fifo.sv
hw/rtl/hbk_seq.sv
hw/rtl/hid_boot_report_key_event_diff.sv
dv/testbench.sv
